### rtl/lrupr_pkg.sv
package lrupr_pkg;

  localparam int CAPACITY  = 16;
  localparam int PAGE_BITS = 32;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int CFG_W     = 5;
  localparam int OUT_W     = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
  localparam logic [OUT_W-1:0] HIT_MAX   = {OUT_W{1'b1}};

  typedef logic [PAGE_BITS-1:0] page_t;

  // per-cell control from the top level
  typedef struct packed {
    logic load;       // request accepted this cycle
    logic hit;        // request found somewhere in the row
    logic in_window;  // cell lies inside the frame limit
    logic valid;      // cell holds a resident page
  } cell_ctl_t;

endpackage

### rtl/lru_page_replacement_core.sv
// Fully associative LRU page store. Each request carries a page number; the
// page is looked up among the resident pages, which sit in a row of cells in
// recency order (cell 0 most recent). A hit moves the page to the front and
// bumps a saturating hit count; a miss inserts the page at the front and, when
// the frame limit is already full, evicts and reports the least recent page.
// One request is taken every clock cycle: busy is held low, and the result
// appears on the out_ ports, marked by out_valid, in the cycle after start.
// The rate rests on the compare-and-shift across the cell row, done combinationally.
// The receiver cannot stall, so every result must be taken in its one cycle.
// cfg_wr_data sets the frame limit (0 acts as 1, above 16 acts as 16); lower
// it only while idle. Lowering it silently drops the surplus least recent
// pages at the next request; only a normal replacement eviction is reported.
module lru_page_replacement_core
  import lrupr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [31:0]      in_page_number,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  output logic             out_valid,
  output logic             out_is_hit,
  output logic             out_evicted_valid,
  output logic [31:0]      out_evicted_page,
  output logic [31:0]      out_hit_total
);

  logic [CFG_W-1:0] limit_cfg_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [OUT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic             ov_r, ov_nxt;
  logic             hit_r, hit_nxt;
  logic             evv_r, evv_nxt;
  logic [31:0]      evp_r, evp_nxt;

  logic             accept;
  page_t            req_page;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] eff_count;
  logic             hit;
  logic             full;
  page_t            evict_pg;

  page_t            cell_page [CAPACITY];
  logic             above     [CAPACITY+1];
  cell_ctl_t        ctl       [CAPACITY];

  // never stalls: one request per cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // take only the low PAGE_BITS of the request
  assign req_page = PAGE_BITS'(in_page_number);

  // clamp the frame limit into 1..CAPACITY
  always_comb begin
    if (limit_cfg_r == '0) begin
      limit = CNT_W'(1);
    end else if (32'(limit_cfg_r) > CAPACITY) begin
      limit = CNT_W'(CAPACITY);
    end else begin
      limit = CNT_W'(limit_cfg_r);
    end
  end

  // drop resident pages beyond a lowered limit
  assign eff_count = (count_r > limit) ? limit : count_r;

  // cell row: the request page enters cell 0, the match chain ripples down
  assign above[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ctl[i].load      = accept;
    assign ctl[i].hit       = hit;
    assign ctl[i].in_window = (CNT_W'(i) < limit);
    assign ctl[i].valid     = (CNT_W'(i) < eff_count);

    lrupr_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .req_page  (req_page),
      .nb_page   ((i == 0) ? req_page : cell_page[(i == 0) ? 0 : i-1]),
      .above_in  (above[i]),
      .above_out (above[i+1]),
      .page      (cell_page[i])
    );
  end

  assign hit  = above[CAPACITY];
  assign full = (eff_count >= limit);

  // least recent page inside the window
  assign evict_pg = cell_page[IDX_W'(limit - CNT_W'(1))];

  always_comb begin
    count_nxt   = count_r;
    hit_cnt_nxt = hit_cnt_r;
    ov_nxt      = accept;
    hit_nxt     = hit_r;
    evv_nxt     = evv_r;
    evp_nxt     = evp_r;
    if (accept) begin
      hit_nxt = hit;
      evv_nxt = 1'b0;
      evp_nxt = '0;
      if (hit) begin
        count_nxt = eff_count;
        if (hit_cnt_r != HIT_MAX) begin
          hit_cnt_nxt = hit_cnt_r + OUT_W'(1);
        end
      end else if (full) begin
        // replace the least recent page and report it
        count_nxt = eff_count;
        evv_nxt   = 1'b1;
        evp_nxt   = 32'(evict_pg);
      end else begin
        count_nxt = eff_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_cfg_r <= CFG_RESET;
      count_r     <= '0;
      hit_cnt_r   <= '0;
      ov_r        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_cfg_r <= cfg_wr_data;
      end
      count_r   <= count_nxt;
      hit_cnt_r <= hit_cnt_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // result payload: no reset needed
  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    evv_r <= evv_nxt;
    evp_r <= evp_nxt;
  end

  assign out_valid         = ov_r;
  assign out_is_hit        = hit_r;
  assign out_evicted_valid = evv_r;
  assign out_evicted_page  = evp_r;
  assign out_hit_total     = hit_cnt_r;

  // a result never claims both a hit and an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_hit && out_evicted_valid))
    else $error("hit result also reports an eviction");

  // without an eviction the reported page is zero
  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted_valid) |-> (out_evicted_page == '0))
    else $error("evicted page set without eviction");

  // resident count never exceeds the limit in force at the request
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept && rst_n) |-> (count_r <= $past(limit)))
    else $error("resident count above frame limit");

  // the hit total moves only on a hit
  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_hit && $past(rst_n)) |-> $stable(hit_cnt_r))
    else $error("hit total changed on a miss");

endmodule

### rtl/lrupr_cell.sv
module lrupr_cell
  import lrupr_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  page_t     req_page,
  input  page_t     nb_page,     // page of the next more recent cell
  input  logic      above_in,    // a more recent cell matched
  output logic      above_out,
  output page_t     page
);

  page_t page_r;
  page_t page_nxt;
  logic  match;
  logic  shift;

  assign match     = ctl.valid && (page_r == req_page);
  assign above_out = above_in || match;

  // on a hit, shift down to and including the matching cell; on a miss,
  // shift the whole window so the last frame drops out
  assign shift = ctl.load && (ctl.hit ? !above_in : ctl.in_window);

  always_comb begin
    page_nxt = page_r;
    if (shift) begin
      page_nxt = nb_page;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

  assign page = page_r;

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lrupr_pkg::*;

  // Generous bound: ~700 requests with idle gaps between them, plus drains.
  localparam int CYCLE_LIMIT = 200000;

  // One result as the block reports it
  typedef struct packed {
    logic             is_hit;
    logic             evicted_valid;
    logic [OUT_W-1:0] evicted_page;
    logic [OUT_W-1:0] hit_total;
  } lookup_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [31:0]      in_page_number = '0;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             out_valid;
  logic             out_is_hit;
  logic             out_evicted_valid;
  logic [31:0]      out_evicted_page;
  logic [31:0]      out_hit_total;

  // Shadow copy of the page store, kept in recency order (slot 0 most recent)
  page_t            shadow_pages [CAPACITY];
  int unsigned      shadow_resident = 0;
  logic [OUT_W-1:0] shadow_hits = '0;
  logic [CFG_W-1:0] shadow_frames = CFG_RESET;

  lookup_result_t   pending_results [$];
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;

  lru_page_replacement_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_page_number   (in_page_number),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_is_hit       (out_is_hit),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page),
    .out_hit_total    (out_hit_total)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out the result of one request and advance the shadow store.
  function automatic lookup_result_t lookup_page(input logic [31:0] number);
    lookup_result_t res;
    page_t          page;
    int unsigned    limit;
    int unsigned    slot;
    bit             found;
    page = page_t'(number);
    res = '0;
    found = 1'b0;
    slot = 0;
    // Clamp the frame limit to 1..CAPACITY
    limit = shadow_frames;
    if (limit < 1) limit = 1;
    if (limit > CAPACITY) limit = CAPACITY;
    // Drop, unreported, whatever a lowered limit has pushed out
    if (shadow_resident > limit) shadow_resident = limit;
    for (int i = 0; i < shadow_resident; i++) begin
      if (!found && shadow_pages[i] == page) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      res.is_hit = 1'b1;
      if (shadow_hits != HIT_MAX) shadow_hits = shadow_hits + OUT_W'(1);
    end else if (shadow_resident >= limit) begin
      res.evicted_valid = 1'b1;
      res.evicted_page = OUT_W'(shadow_pages[limit-1]);
      slot = limit - 1;
    end else begin
      slot = shadow_resident;
      shadow_resident++;
    end
    if (slot > CAPACITY - 1) slot = CAPACITY - 1;
    for (int i = slot; i > 0; i--) shadow_pages[i] = shadow_pages[i-1];
    shadow_pages[0] = page;
    res.hit_total = shadow_hits;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h, want %h", cycle_count, field, got, want);
    mismatch_count++;
  endtask

  // Watch both channels at every edge: check the result leaving the block,
  // track register writes, and predict each request as it is accepted.
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (pending_results.size() == 0) begin
          $display("unexpected result at cycle %0d", cycle_count);
          mismatch_count++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (out_is_hit !== want.is_hit)
            report_mismatch("is_hit", 32'(out_is_hit), 32'(want.is_hit));
          if (out_evicted_valid !== want.evicted_valid)
            report_mismatch("evicted_valid", 32'(out_evicted_valid),
                            32'(want.evicted_valid));
          if (out_evicted_page !== want.evicted_page)
            report_mismatch("evicted_page", out_evicted_page, want.evicted_page);
          if (out_hit_total !== want.hit_total)
            report_mismatch("hit_total", out_hit_total, want.hit_total);
        end
      end
      if (cfg_wr_en) shadow_frames = cfg_wr_data;
      if (start && busy === 1'b0)
        pending_results = {pending_results, lookup_page(in_page_number)};
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offer one request, hold it until the block takes it, then, for a nonzero
  // gap, drop start and idle for the gap. With no gap, start stays high so the next request follows at once.
  task automatic send_request(input logic [31:0] number, input int unsigned gap);
    in_page_number <= number;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write the frame limit; only ever called with the block idle.
  task automatic write_frames(input logic [CFG_W-1:0] frames);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= frames;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Extreme page numbers at the reset limit, with a hit on all-zeros and all-ones.
  task automatic test_page_extremes();
    send_request(32'h0000_0000, 0);
    send_request(32'hFFFF_FFFF, 3);
    send_request(32'h0000_0000, 0);
    send_request(32'hFFFF_FFFF, 0);
    send_request(32'h8000_0000, 1);
    send_request(32'h0000_0001, 0);
    drain_results();
  endtask

  // Limit lowered below the resident count, limit zero, limit above capacity,
  // and a normal eviction from a small store.
  task automatic test_frame_limit_cases();
    write_frames(CFG_W'(2));
    send_request(32'h0000_0001, 0);
    drain_results();
    write_frames(CFG_W'(1));
    send_request(32'h8000_0000, 0);
    drain_results();
    write_frames(CFG_W'(0));
    send_request(32'h8000_0000, 0);
    send_request(32'h0000_0007, 0);
    drain_results();
    write_frames(CFG_W'(31));
    send_request(32'h0000_0007, 2);
    send_request(32'h0000_0009, 0);
    drain_results();
    write_frames(CFG_W'(3));
    send_request(32'h0000_000A, 0);
    send_request(32'h0000_000B, 0);
    send_request(32'h0000_0009, 0);
    drain_results();
  endtask

  // Mostly draw from a small pool a little larger than the limit, so hits,
  // reorders and evictions are all frequent; mix in near-twins that differ in
  // one bit and fully random pages.
  task automatic run_traffic_phase(input logic [CFG_W-1:0] frames, input int unsigned count,
                                   input bit burst, input bit mid_drain);
    page_t       pool [CAPACITY+4];
    int unsigned pool_size;
    int unsigned limit;
    logic [31:0] number;
    limit = frames;
    if (limit < 1) limit = 1;
    if (limit > CAPACITY) limit = CAPACITY;
    pool_size = limit + $urandom_range(1, 4);
    for (int i = 0; i < pool_size; i++) begin
      case ($urandom_range(0, 7))
        0: pool[i] = '0;
        1: pool[i] = '1;
        2, 3: begin
          if (i > 0)
            pool[i] = pool[$urandom_range(0, i-1)] ^ (page_t'(1) << $urandom_range(0, 31));
          else
            pool[i] = page_t'($urandom);
        end
        default: pool[i] = page_t'($urandom);
      endcase
    end
    write_frames(frames);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 85) number = pool[$urandom_range(0, pool_size-1)];
      else number = $urandom;
      send_request(number, burst ? 0 : $urandom_range(0, 19));
      // Hold off mid-phase until the block has answered everything
      if (mid_drain && n == count / 2) drain_results();
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] frames_list [10];
    frames_list = '{CFG_W'(16), CFG_W'(1), CFG_W'(0), CFG_W'(8), CFG_W'(31),
                    CFG_W'(3), CFG_W'($urandom_range(2, 15)), CFG_W'(17),
                    CFG_W'(16), CFG_W'($urandom_range(0, 31))};
    for (int p = 0; p < 10; p++)
      run_traffic_phase(frames_list[p], 70, (p % 3) == 0, p == 4);
  endtask

  initial begin
    for (int i = 0; i < CAPACITY; i++) shadow_pages[i] = '0;
    // Hold reset, then release
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_page_extremes();
    test_frame_limit_cases();
    test_random_traffic();
    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
